// File: src/mp2d_pkg.sv
// Shared types and constants for the padded 2-D max pooling block.
// No dependencies.
`default_nettype none
package mp2d_pkg;
    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 6;

    localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_CHANS  = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_WINDOW = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_STEP   = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_PAD    = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROW   = 6'b000010,
        S_COL   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;
endpackage
`default_nettype wire

// File: src/max_pool_2d_padded_core.sv
// Streaming 2-D max pooling with zero padding: frame memory, window sequencer.
// Depends on mp2d_pkg.
//
//   channel | dir | handshake            | payload
//   input   | in  | i_valid / o_stall    | i_sample_value
//   result  | out | o_valid / i_stall    | o_pooled_value, o_out_row, o_out_col,
//           |     |                      | o_out_channel, o_frame_done
//   config  | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is written to the frame memory in the cycle it is accepted. The sequencer
// then walks window rows and columns one per cycle, and for each finished window
// reads window_size^2 entries through the one memory read port (one per cycle,
// then a drain state and an emit state). Input is stalled until all of the
// item's windows are sent. Reset is synchronous; memory contents are not cleared.
`default_nettype none
module max_pool_2d_padded_core #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_WINDOW   = 8,
    parameter int VALUE_BITS   = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  signed [VALUE_BITS-1:0]     i_sample_value,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [VALUE_BITS-1:0]     o_pooled_value,
    output logic [5:0]                       o_out_row,
    output logic [5:0]                       o_out_col,
    output logic [3:0]                       o_out_channel,
    output logic                             o_frame_done,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mp2d_pkg::CfgIdxBits-1:0]  i_cfg_index,
    input  wire  [mp2d_pkg::CfgDataBits-1:0] i_cfg_data
);
    import mp2d_pkg::*;

    localparam int Depth = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW    = $clog2(MAX_HEIGHT + MAX_WIDTH + 4 * MAX_WINDOW + 16) + 1;
    localparam int CHW   = $clog2(MAX_CHANNELS + 1);
    localparam int MW    = $clog2(MAX_WINDOW + 1);

    // ---------------- configuration ----------------
    logic [5:0] r_cfg_h, r_cfg_w;
    logic [4:0] r_cfg_nc;
    logic [3:0] r_cfg_p, r_cfg_s;
    logic [2:0] r_cfg_pad;
    logic       cfg_wr, cfg_known;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_known   = (i_cfg_index == REG_HEIGHT) || (i_cfg_index == REG_WIDTH) ||
                         (i_cfg_index == REG_CHANS) || (i_cfg_index == REG_WINDOW) ||
                         (i_cfg_index == REG_STEP) || (i_cfg_index == REG_PAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_h   <= 6'd32;
            r_cfg_w   <= 6'd32;
            r_cfg_nc  <= 5'd1;
            r_cfg_p   <= 4'd2;
            r_cfg_s   <= 4'd2;
            r_cfg_pad <= 3'd0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_HEIGHT: r_cfg_h   <= i_cfg_data;
                REG_WIDTH:  r_cfg_w   <= i_cfg_data;
                REG_CHANS:  r_cfg_nc  <= i_cfg_data[4:0];
                REG_WINDOW: r_cfg_p   <= i_cfg_data[3:0];
                REG_STEP:   r_cfg_s   <= i_cfg_data[3:0];
                REG_PAD:    r_cfg_pad <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) settings
    logic [CW-1:0] h, w, p, s, pad, hp, wp;
    logic [CHW-1:0] nc;
    always_comb begin
        h  = (r_cfg_h == 6'd0) ? CW'(1) :
             ((CW'(r_cfg_h) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(r_cfg_h));
        w  = (r_cfg_w == 6'd0) ? CW'(1) :
             ((CW'(r_cfg_w) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(r_cfg_w));
        nc = (r_cfg_nc == 5'd0) ? CHW'(1) :
             ((CW'(r_cfg_nc) > CW'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : CHW'(r_cfg_nc));
        p  = (r_cfg_p == 4'd0) ? CW'(1) :
             ((CW'(r_cfg_p) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(r_cfg_p));
        s  = (r_cfg_s == 4'd0) ? CW'(1) : CW'(r_cfg_s);
        pad = (CW'(r_cfg_pad) > (p >> 1)) ? (p >> 1) : CW'(r_cfg_pad);
        hp = h + (pad << 1);
        wp = w + (pad << 1);
    end

    function automatic logic [CW-1:0] last_real(input logic [CW-1:0] o, input logic [CW-1:0] pp,
                                                input logic [CW-1:0] pd, input logic [CW-1:0] n);
        logic [CW-1:0] e, lr;
        e  = o + pp - CW'(1);
        lr = (e >= pd) ? e - pd : '0;
        return (lr > n - CW'(1)) ? n - CW'(1) : lr;
    endfunction

    // ---------------- position counters ----------------
    t_state r_state, n_state;
    logic   in_acc;
    logic [CW-1:0]  r_row_cnt, r_col_cnt, cur_r, cur_c;
    logic [CHW-1:0] r_chan_cnt, cur_ch;
    logic           wrap;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign wrap    = (r_row_cnt >= h) || (r_col_cnt >= w) || (r_chan_cnt >= nc);
    assign cur_r   = wrap ? '0 : r_row_cnt;
    assign cur_c   = wrap ? '0 : r_col_cnt;
    assign cur_ch  = wrap ? '0 : r_chan_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (cfg_wr && cfg_known)) begin
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_chan_cnt <= '0;
        end else if (in_acc) begin
            if (cur_ch + CHW'(1) >= nc) begin
                r_chan_cnt <= '0;
                if (cur_c + CW'(1) >= w) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= (cur_r + CW'(1) >= h) ? '0 : cur_r + CW'(1);
                end else begin
                    r_col_cnt <= cur_c + CW'(1);
                    r_row_cnt <= cur_r;
                end
            end else begin
                r_chan_cnt <= cur_ch + CHW'(1);
                r_col_cnt  <= cur_c;
                r_row_cnt  <= cur_r;
            end
        end
    end

    // ---------------- frame memory ----------------
    logic signed [VALUE_BITS-1:0] mem [Depth];
    logic signed [VALUE_BITS-1:0] r_rdata;
    logic [AW-1:0] wr_addr, rd_addr;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] rr, input logic [CW-1:0] cc,
                                              input logic [CHW-1:0] cz);
        return AW'(rr) * AW'(MAX_WIDTH * MAX_CHANNELS) + AW'(cc) * AW'(MAX_CHANNELS) + AW'(cz);
    endfunction

    assign wr_addr = addr_of(cur_r, cur_c, cur_ch);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[wr_addr] <= i_sample_value;
        end
        r_rdata <= mem[rd_addr];
    end

    // ---------------- window sequencer ----------------
    logic [CW-1:0]  r_r, r_c, r_ro, r_co, r_i, r_j;
    logic [CHW-1:0] r_ch;
    logic           r_fend;
    logic [MW-1:0]  r_m, r_k;
    logic           r_p1_vld, r_p1_pad, r_first;
    logic signed [VALUE_BITS-1:0] r_max, cand;
    logic [CW-1:0]  pr, pc;
    logic           elt_real, scan_last, out_free;

    assign pr        = r_ro + CW'(r_m);
    assign pc        = r_co + CW'(r_k);
    assign elt_real  = (pr >= pad) && (pr < pad + h) && (pc >= pad) && (pc < pad + w);
    assign rd_addr   = addr_of(pr - pad, pc - pad, r_ch);
    assign scan_last = (CW'(r_m) == p - CW'(1)) && (CW'(r_k) == p - CW'(1));
    assign out_free  = !o_valid || !i_stall;
    assign cand      = r_p1_pad ? '0 : r_rdata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && hp >= p && wp >= p) n_state = S_ROW;
            S_ROW: begin
                if (r_ro + p > hp) n_state = S_IDLE;
                else if (last_real(r_ro, p, pad, h) == r_r) n_state = S_COL;
            end
            S_COL: begin
                if (r_co + p > wp) n_state = S_ROW;
                else if (last_real(r_co, p, pad, w) == r_c) n_state = S_SCAN;
            end
            S_SCAN:  if (scan_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_COL;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_pad <= !elt_real;
        if (r_p1_vld) begin
            r_first <= 1'b0;
            if (r_first || cand > r_max) r_max <= cand;
        end
        unique case (r_state)
            S_IDLE: begin
                r_r    <= cur_r;
                r_c    <= cur_c;
                r_ch   <= cur_ch;
                r_fend <= (cur_r == h - CW'(1)) && (cur_c == w - CW'(1)) &&
                          (cur_ch == nc - CHW'(1));
                r_ro   <= '0;
                r_i    <= '0;
            end
            S_ROW: begin
                r_co <= '0;
                r_j  <= '0;
                if (r_ro + p <= hp && last_real(r_ro, p, pad, h) != r_r) begin
                    r_ro <= r_ro + s;
                    r_i  <= r_i + CW'(1);
                end
            end
            S_COL: begin
                r_m     <= '0;
                r_k     <= '0;
                r_first <= 1'b1;
                if (r_co + p > wp) begin
                    r_ro <= r_ro + s;
                    r_i  <= r_i + CW'(1);
                end else if (last_real(r_co, p, pad, w) != r_c) begin
                    r_co <= r_co + s;
                    r_j  <= r_j + CW'(1);
                end
            end
            S_SCAN: begin
                if (CW'(r_k) == p - CW'(1)) begin
                    r_k <= '0;
                    r_m <= r_m + MW'(1);
                end else begin
                    r_k <= r_k + MW'(1);
                end
            end
            S_DRAIN: ;
            S_EMIT: begin
                if (out_free) begin
                    r_co <= r_co + s;
                    r_j  <= r_j + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            o_pooled_value <= r_max;
            o_out_row      <= r_i[5:0];
            o_out_col      <= r_j[5:0];
            o_out_channel  <= 4'(r_ch);
            o_frame_done   <= r_fend && (r_ro + s + p > hp) && (r_co + s + p > wp);
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");
    a_p1_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> ($past(r_state) == S_SCAN)) else $error("read data without scan");
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_EMIT)) else $error("drain not followed by emit");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !in_acc) else $error("item taken during window scan");
`endif

endmodule
`default_nettype wire
